@@ hw/rtl/rational_arithmetic_unit_macros.svh @@
// assertion macros shared by the rational arithmetic unit modules
// expects clk and arst_n in the scope of the module that uses them
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define RAU_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/rau_pkg.sv @@
// shared types and constants of the rational arithmetic unit
// used by rau_ctrl, rau_dp and rational_arithmetic_unit; no dependencies
package rau_pkg;

	// operand and internal widths
	localparam int IN_WIDTH  = 16;
	localparam int DEN_W     = IN_WIDTH - 1;
	localparam int OP_W      = IN_WIDTH + 1;
	localparam int PROD_W    = 2 * OP_W;
	localparam int ACC_W     = 2 * IN_WIDTH + 1;
	localparam int MAG_W     = ACC_W;
	localparam int SHIFT_W   = $clog2(MAG_W);
	localparam int CNT_W     = $clog2(MAG_W);
	localparam int RES_NUM_W = 32;
	localparam int RES_DEN_W = 31;

	// result of a divide by a zero fraction: -1 over 1
	localparam logic [RES_NUM_W-1:0] ERR_NUM = {RES_NUM_W{1'b1}};
	localparam logic [RES_DEN_W-1:0] ERR_DEN = RES_DEN_W'(1);

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_SUB = 2'd1,
		MODE_MUL = 2'd2,
		MODE_DIV = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t                      mode;
		logic signed [IN_WIDTH-1:0] a_num;
		logic        [DEN_W-1:0]    a_den;
		logic signed [IN_WIDTH-1:0] b_num;
		logic        [DEN_W-1:0]    b_den;
	} rau_in_t;

	typedef struct packed {
		logic signed [RES_NUM_W-1:0] res_num;
		logic        [RES_DEN_W-1:0] res_den;
		logic                        div_zero;
	} rau_out_t;

	// which product the shared multiplier forms
	typedef enum logic [1:0] {
		MSEL_T1,
		MSEL_T2,
		MSEL_DEN
	} mul_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_T1,
		ST_MUL_T2,
		ST_MUL_DEN,
		ST_ABS,
		ST_GCD,
		ST_GSET,
		ST_DIVN_LD,
		ST_DIVN,
		ST_DIVD_LD,
		ST_DIVD,
		ST_STORE,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic     load_in;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     abs_ld;
		logic     gcd_step;
		logic     g_ld;
		logic     div_ld_num;
		logic     div_ld_den;
		logic     div_step;
		logic     num_ld;
		logic     den_ld;
		logic     err_ld;
	} rau_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_zero;
		logic two_terms;
		logic gcd_done;
		logic div_last;
	} rau_sts_t;

endpackage

@@ hw/rtl/rau_dp.sv @@
// datapath: operand register, shared multiplier, binary gcd, restoring divider
// depends on rau_pkg and rational_arithmetic_unit_macros.svh
`include "rational_arithmetic_unit_macros.svh"

module rau_dp
	import rau_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  rau_in_t  operand,
	input  rau_cmd_t cmd,
	output rau_sts_t sts,
	output rau_out_t result
);

	rau_in_t                   in_q;
	logic signed [ACC_W-1:0]   num_q;
	logic signed [ACC_W-1:0]   den_q;
	logic                      neg_q;
	logic        [MAG_W-1:0]   x_q;
	logic        [MAG_W-1:0]   y_q;
	logic        [MAG_W-1:0]   un_q;
	logic        [MAG_W-1:0]   ud_q;
	logic        [SHIFT_W-1:0] k_q;
	logic        [MAG_W-1:0]   g_q;
	logic        [MAG_W-1:0]   quo_q;
	logic        [MAG_W-1:0]   rem_q;
	logic        [CNT_W-1:0]   cnt_q;
	rau_out_t                  res_q;

	logic signed [OP_W-1:0]    op_a;
	logic signed [OP_W-1:0]    op_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [ACC_W-1:0]   prod_t;
	logic        [MAG_W-1:0]   x_or_y;
	logic        [MAG_W:0]     rem_sh;
	logic                      rem_ge;
	logic        [MAG_W:0]     rem_diff;
	logic signed [MAG_W:0]     quo_s;
	logic signed [MAG_W:0]     num_s;

	// multiplier operand selection by product and operation
	always_comb begin
		op_a = OP_W'(in_q.a_num);
		op_b = $signed(OP_W'(in_q.b_den));
		case (cmd.mul_sel)
			MSEL_T1: begin
				op_a = OP_W'(in_q.a_num);
				op_b = (in_q.mode == MODE_MUL) ? OP_W'(in_q.b_num)
				                               : $signed(OP_W'(in_q.b_den));
			end
			MSEL_T2: begin
				op_a = $signed(OP_W'(in_q.a_den));
				op_b = OP_W'(in_q.b_num);
			end
			MSEL_DEN: begin
				op_a = $signed(OP_W'(in_q.a_den));
				op_b = (in_q.mode == MODE_DIV) ? OP_W'(in_q.b_num)
				                               : $signed(OP_W'(in_q.b_den));
			end
			default: begin
				op_a = OP_W'(in_q.a_num);
				op_b = $signed(OP_W'(in_q.b_den));
			end
		endcase
	end

	assign prod   = op_a * op_b;
	assign prod_t = ACC_W'(prod);

	// gcd and divider helpers
	assign x_or_y   = x_q | y_q;
	assign rem_sh   = {rem_q, quo_q[MAG_W-1]};
	assign rem_ge   = rem_sh >= {1'b0, g_q};
	assign rem_diff = rem_sh - {1'b0, g_q};
	assign quo_s    = $signed({1'b0, quo_q});
	assign num_s    = neg_q ? -quo_s : quo_s;

	// status toward the controller
	assign sts.div_zero  = (in_q.mode == MODE_DIV) && (in_q.b_num == '0);
	assign sts.two_terms = (in_q.mode == MODE_ADD) || (in_q.mode == MODE_SUB);
	assign sts.gcd_done  = (x_q == '0) || (y_q == '0);
	assign sts.div_last  = cnt_q == CNT_W'(MAG_W - 1);

	// operand capture and cross products
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q <= operand;
		end
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				MSEL_T1:  num_q <= prod_t;
				MSEL_T2:  num_q <= (in_q.mode == MODE_SUB) ? num_q - prod_t : num_q + prod_t;
				MSEL_DEN: den_q <= prod_t;
				default:  den_q <= prod_t;
			endcase
		end
	end

	// sign split and binary gcd on magnitudes
	always_ff @(posedge clk) begin
		if (cmd.abs_ld) begin
			neg_q <= num_q[ACC_W-1] ^ den_q[ACC_W-1];
			x_q   <= num_q[ACC_W-1] ? MAG_W'(-num_q) : MAG_W'(num_q);
			un_q  <= num_q[ACC_W-1] ? MAG_W'(-num_q) : MAG_W'(num_q);
			y_q   <= den_q[ACC_W-1] ? MAG_W'(-den_q) : MAG_W'(den_q);
			ud_q  <= den_q[ACC_W-1] ? MAG_W'(-den_q) : MAG_W'(den_q);
			k_q   <= '0;
		end else if (cmd.gcd_step) begin
			if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_q >= y_q) begin
				x_q <= x_q - y_q;
			end else begin
				y_q <= y_q - x_q;
			end
		end
		// gcd of zero and zero is taken as one
		if (cmd.g_ld) begin
			g_q <= (x_or_y == '0) ? MAG_W'(1) : (x_or_y << k_q);
		end
	end

	// restoring divider, one quotient bit per cycle while div_step is set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_ld_num || cmd.div_ld_den) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_ld_num) begin
			quo_q <= un_q;
			rem_q <= '0;
		end else if (cmd.div_ld_den) begin
			quo_q <= ud_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[MAG_W-2:0], rem_ge};
			rem_q <= rem_ge ? MAG_W'(rem_diff) : MAG_W'(rem_sh);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.err_ld) begin
			res_q.res_num  <= ERR_NUM;
			res_q.res_den  <= ERR_DEN;
			res_q.div_zero <= 1'b1;
		end else begin
			if (cmd.num_ld) begin
				res_q.res_num  <= RES_NUM_W'(num_s);
				res_q.div_zero <= 1'b0;
			end
			if (cmd.den_ld) begin
				res_q.res_den <= RES_DEN_W'(quo_q);
			end
		end
	end

	assign result = res_q;

	// checks
	`RAU_ASSERT_SAME(a_gcd_live, cmd.gcd_step, !sts.gcd_done, "gcd step after termination")
	`RAU_ASSERT_NEXT(a_g_nonzero, cmd.g_ld, g_q != '0, "zero divisor loaded")
	`RAU_ASSERT_NEXT(a_exact_quo, cmd.div_step && sts.div_last, rem_q == '0,
		"division by gcd left a remainder")

endmodule

@@ hw/rtl/rau_ctrl.sv @@
// controller state machine: sequences products, gcd and the two divisions
// depends on rau_pkg and rational_arithmetic_unit_macros.svh
`include "rational_arithmetic_unit_macros.svh"

module rau_ctrl
	import rau_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  rau_sts_t sts,
	output rau_cmd_t cmd,
	output logic     busy,
	output logic     done
);

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:    if (start) state_nxt = ST_MUL_T1;
			ST_MUL_T1: begin
				if (sts.div_zero)       state_nxt = ST_FINISH;
				else if (sts.two_terms) state_nxt = ST_MUL_T2;
				else                    state_nxt = ST_MUL_DEN;
			end
			ST_MUL_T2:  state_nxt = ST_MUL_DEN;
			ST_MUL_DEN: state_nxt = ST_ABS;
			ST_ABS:     state_nxt = ST_GCD;
			ST_GCD:     if (sts.gcd_done) state_nxt = ST_GSET;
			ST_GSET:    state_nxt = ST_DIVN_LD;
			ST_DIVN_LD: state_nxt = ST_DIVN;
			ST_DIVN:    if (sts.div_last) state_nxt = ST_DIVD_LD;
			ST_DIVD_LD: state_nxt = ST_DIVD;
			ST_DIVD:    if (sts.div_last) state_nxt = ST_STORE;
			ST_STORE:   state_nxt = ST_FINISH;
			ST_FINISH:  state_nxt = ST_IDLE;
			default:    state_nxt = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd = '0;
		cmd.mul_sel = MSEL_T1;
		unique case (state_q)
			ST_IDLE:    cmd.load_in = start;
			ST_MUL_T1: begin
				cmd.err_ld  = sts.div_zero;
				cmd.mul_en  = !sts.div_zero;
				cmd.mul_sel = MSEL_T1;
			end
			ST_MUL_T2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MSEL_T2;
			end
			ST_MUL_DEN: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MSEL_DEN;
			end
			ST_ABS:     cmd.abs_ld = 1'b1;
			ST_GCD:     cmd.gcd_step = !sts.gcd_done;
			ST_GSET:    cmd.g_ld = 1'b1;
			ST_DIVN_LD: cmd.div_ld_num = 1'b1;
			ST_DIVN:    cmd.div_step = 1'b1;
			ST_DIVD_LD: begin
				cmd.num_ld     = 1'b1;
				cmd.div_ld_den = 1'b1;
			end
			ST_DIVD:    cmd.div_step = 1'b1;
			ST_STORE:   cmd.den_ld = 1'b1;
			ST_FINISH:  cmd = '0;
			default:    cmd = '0;
		endcase
	end

	assign busy = state_q != ST_IDLE;
	assign done = state_q == ST_FINISH;

	// checks
	`RAU_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
	`RAU_ASSERT_NEXT(a_done_free, done, !busy && !done, "not idle after result beat")
	`RAU_ASSERT_SAME(a_fall_done, $fell(busy), $past(done), "busy dropped without a result")

endmodule

@@ hw/rtl/rational_arithmetic_unit.sv @@
// top level of the rational arithmetic unit: controller plus datapath
// depends on rau_pkg, rau_ctrl and rau_dp
//
// channel   direction  handshake             payload
// operand   in         start & !busy         rau_in_t  (mode, a_num, a_den, b_num, b_den)
// result    out        done, one cycle wide  rau_out_t (res_num, res_den, div_zero)
//
// one item at a time; a divide by zero goes from MUL_T1 straight to FINISH for its result beat,
// otherwise MUL_T1, MUL_T2 (add and subtract only), MUL_DEN, ABS, GCD, GSET, DIVN_LD, DIVN,
// DIVD_LD, DIVD, STORE and FINISH in turn; the next beat is taken in the cycle after the result
// GCD steps until x or y is zero, and the shared restoring divider runs MAG_W steps, twice
// reset clears the state register and the divide counter; the receiver cannot stall
module rational_arithmetic_unit
	import rau_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  rau_in_t  operand,
	output logic     busy,
	output logic     done,
	output rau_out_t result
);

	rau_cmd_t cmd;
	rau_sts_t sts;

	// sequencer
	rau_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// arithmetic
	rau_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (operand),
		.cmd     (cmd),
		.sts     (sts),
		.result  (result)
	);

endmodule
